// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an implication on every clock edge outside reset.
`define RBD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define RBD_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/rbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rbd_pkg;

  localparam int MAX_OUT_WIDTH_DEF = 512;
  localparam int MAX_GROUP_DEF     = 8;

  // Field widths sized for the full parameter ranges
  localparam int PIX_W   = 16;
  localparam int LINE_W  = 12;
  localparam int TAG_W   = 13;
  localparam int COL_W   = 9;
  localparam int XW      = 13;
  localparam int GW      = 17;
  localparam int IDX_W   = 13;
  localparam int CNT_W   = 5;
  localparam int ROWS_W  = 4;
  localparam int DOFF_W  = 5;
  localparam int RCP_W   = 21;
  localparam int F_W     = 11;
  localparam int FQ_W    = 5;
  localparam int FR_W    = 7;
  localparam int CFG_W   = 10;
  localparam int CIDX_W  = 2;
  localparam int QDEPTH  = 4;
  localparam int QAW     = 2;
  localparam int SETTLE  = 3;

  localparam logic [IDX_W-1:0] IDX_MAX = '1;

  // RGB565 channel layout
  localparam logic [PIX_W-1:0] RED_MASK = 16'b1111100000000000;
  localparam logic [PIX_W-1:0] GRN_MASK = 16'b0000011111100000;
  localparam logic [PIX_W-1:0] BLU_MASK = 16'b0000000000011111;
  localparam int RED_LSB = 11;
  localparam int GRN_LSB = 5;

  localparam int FACTOR_SCALE = 100;
  localparam int F_MIN        = 100;
  // floor(f/100) as (f * QMUL) >> QSH, exact for f below 1700
  localparam int QMUL = 10486;
  localparam int QSH  = 20;

  localparam logic [CFG_W-1:0] FACTOR_RST = 10'd200;
  localparam logic [CFG_W-1:0] WIDTH_RST  = 10'd160;

  typedef enum logic [CIDX_W-1:0] {
    REG_FACTOR,
    REG_WIDTH,
    REG_MODE
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_PIXEL,
    OP_COL,
    OP_ZERO
  } op_kind_t;

  // One queued job from the front to the back
  typedef struct packed {
    op_kind_t                  kind;
    logic [PIX_W-1:0]          pixel;
    logic                      first;
    logic [XW-1:0]             x;
    logic [DOFF_W-1:0]         doff;
    logic                      emit;
    logic                      first_row;
    logic                      last;
    logic signed [TAG_W-1:0]   tag;
  } op_t;

  // Settings derived from the configuration registers
  typedef struct packed {
    logic [FQ_W-1:0]  fq;
    logic [FR_W-1:0]  fr;
    logic [CNT_W-1:0] c;
    logic             frac;
    logic             mode;
    logic [XW-1:0]    w;
    logic [RCP_W-1:0] recip;
  } dcfg_t;

  typedef struct packed {
    logic init_busy;
    logic settle_busy;
  } hold_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_COLS,
    F_CLR
  } front_state_t;

  typedef enum logic [1:0] {
    B_INIT,
    B_IDLE,
    B_MUL,
    B_WR
  } back_state_t;

endpackage
`default_nettype wire

// ----- rtl/rbd_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rbd_in_if import rbd_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PIX_W-1:0]  pixel_in;
  logic              end_of_line;
  logic [LINE_W-1:0] line_number;

  modport source (output valid, pixel_in, end_of_line, line_number, input ready);
  modport sink (input valid, pixel_in, end_of_line, line_number, output ready);
endinterface
`default_nettype wire

// ----- rtl/rbd_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface rbd_out_if import rbd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [PIX_W-1:0]        pixel_out;
  logic [COL_W-1:0]        column;
  logic signed [TAG_W-1:0] out_line;
  logic                    last_of_row;

  modport source (output valid, pixel_out, column, out_line, last_of_row, input ready);
  modport sink (input valid, pixel_out, column, out_line, last_of_row, output ready);
endinterface
`default_nettype wire

// ----- rtl/rbd_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbd_fifo import rbd_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire op_t  push_op,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output op_t       pop_op
);

  op_t            slot_r [QDEPTH];
  logic [QAW-1:0] wp_r;
  logic [QAW-1:0] rp_r;
  logic [QAW:0]   cnt_r;
  logic           do_push;
  logic           do_pop;

  assign push_ready = (cnt_r != (QAW+1)'(QDEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_op     = slot_r[rp_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Store incoming jobs
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wp_r] <= push_op;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/rbd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbd_front import rbd_pkg::*; #(
  parameter int MAX_GROUP = MAX_GROUP_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rbd_in_if.sink     in_ch,
  input  wire dcfg_t dcfg,
  input  wire hold_t hold,
  output logic       push_valid,
  input  wire logic  push_ready,
  output op_t        push_op
);

  localparam int DOFF_MAX = 2 * MAX_GROUP - 1;

  front_state_t            state_r, state_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [XW-1:0]           x_r, x_nxt;
  logic [GW-1:0]           g_r, g_nxt;
  logic [FR_W-1:0]         rem_r, rem_nxt;
  logic [CNT_W-1:0]        n_r, n_nxt;
  logic [ROWS_W-1:0]       rows_r, rows_nxt;
  logic                    eol_r, eol_nxt;
  logic signed [TAG_W-1:0] tag_r, tag_nxt;

  logic                    accept;
  logic                    emitting;
  logic                    col_done;
  logic                    next_done;
  logic                    col_last;
  logic [GW:0]             g_end;
  logic [GW-1:0]           g_step;
  logic [FR_W:0]           rem_sum;
  logic                    carry;
  logic [FR_W-1:0]         rem_step;
  logic [GW:0]             gap;
  logic [DOFF_W-1:0]       doff;
  logic [CNT_W:0]          rows_inc;
  logic [ROWS_W-1:0]       rows_wrap;

  assign accept   = in_ch.valid && in_ch.ready;
  assign emitting = ((CNT_W+1)'(rows_r) + 1'b1) >= (CNT_W+1)'(dcfg.c);

  // Column bookkeeping: group start and its successor
  always_comb begin
    g_end    = {1'b0, g_r} + (GW+1)'(dcfg.c) - 1'b1;
    rem_sum  = (FR_W+1)'(rem_r) + (FR_W+1)'(dcfg.fr);
    carry    = rem_sum >= (FR_W+1)'(FACTOR_SCALE);
    rem_step = carry ? FR_W'(rem_sum - (FR_W+1)'(FACTOR_SCALE)) : FR_W'(rem_sum);
    g_step   = g_r + GW'(dcfg.fq) + GW'(carry);
    col_done = (x_r < dcfg.w) && (n_r < CNT_W'(MAX_GROUP)) &&
               ((g_end <= (GW+1)'(idx_r)) || (eol_r && (g_r <= GW'(idx_r))));
    next_done = ((XW+1)'(x_r) + 1'b1 < (XW+1)'(dcfg.w)) &&
                (n_r + 1'b1 < CNT_W'(MAX_GROUP)) && (g_step <= GW'(idx_r));
    col_last = (x_r == dcfg.w - 1'b1) || (eol_r && emitting && !next_done);
    gap      = (GW+1)'(idx_r) - {1'b0, g_r};
    doff     = (gap > (GW+1)'(DOFF_MAX)) ? DOFF_W'(DOFF_MAX) : DOFF_W'(gap);
    rows_inc = (CNT_W+1)'(rows_r) + 1'b1;
    if (rows_inc >= (CNT_W+1)'(dcfg.c)) begin
      rows_wrap = (dcfg.frac && !dcfg.mode) ? ROWS_W'(1) : '0;
    end else begin
      rows_wrap = ROWS_W'(rows_inc);
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: if (accept) state_nxt = F_COLS;
      F_COLS: begin
        if (!col_done) begin
          state_nxt = (eol_r && emitting) ? F_CLR : F_IDLE;
        end
      end
      F_CLR: if (x_r >= dcfg.w) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  // Outputs and datapath
  always_comb begin
    in_ch.ready = 1'b0;
    push_valid  = 1'b0;
    push_op     = '0;
    idx_nxt     = idx_r;
    x_nxt       = x_r;
    g_nxt       = g_r;
    rem_nxt     = rem_r;
    n_nxt       = n_r;
    rows_nxt    = rows_r;
    eol_nxt     = eol_r;
    tag_nxt     = tag_r;
    unique case (state_r)
      F_IDLE: begin
        // take a word when its pixel job fits in the queue and no hold is active
        in_ch.ready   = push_ready && !hold.init_busy && !hold.settle_busy;
        push_valid    = accept;
        push_op.kind  = OP_PIXEL;
        push_op.pixel = in_ch.pixel_in;
        push_op.first = (idx_r == '0);
        if (accept) begin
          eol_nxt = in_ch.end_of_line;
          tag_nxt = $signed({1'b0, in_ch.line_number}) -
                    $signed(TAG_W'(dcfg.frac));
          n_nxt   = '0;
        end
      end
      F_COLS: begin
        push_op.kind      = OP_COL;
        push_op.x         = x_r;
        push_op.doff      = doff;
        push_op.emit      = emitting;
        push_op.first_row = (rows_r == '0);
        push_op.last      = col_last;
        push_op.tag       = tag_r;
        if (col_done) begin
          push_valid = 1'b1;
          if (push_ready) begin
            x_nxt   = x_r + 1'b1;
            g_nxt   = g_step;
            rem_nxt = rem_step;
            n_nxt   = n_r + CNT_W'(emitting);
          end
        end else if (!eol_r) begin
          if (idx_r != IDX_MAX) idx_nxt = idx_r + 1'b1;
        end else if (!emitting) begin
          rows_nxt = rows_wrap;
          idx_nxt  = '0;
          x_nxt    = '0;
          g_nxt    = '0;
          rem_nxt  = '0;
        end
      end
      F_CLR: begin
        // drop the rest of the row store entries
        push_op.kind = OP_ZERO;
        push_op.x    = x_r;
        if (x_r < dcfg.w) begin
          push_valid = 1'b1;
          if (push_ready) x_nxt = x_r + 1'b1;
        end else begin
          rows_nxt = rows_wrap;
          idx_nxt  = '0;
          x_nxt    = '0;
          g_nxt    = '0;
          rem_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      idx_r   <= '0;
      x_r     <= '0;
      g_r     <= '0;
      rem_r   <= '0;
      n_r     <= '0;
      rows_r  <= '0;
      eol_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
      x_r     <= x_nxt;
      g_r     <= g_nxt;
      rem_r   <= rem_nxt;
      n_r     <= n_nxt;
      rows_r  <= rows_nxt;
      eol_r   <= eol_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r <= tag_nxt;
  end

endmodule
`default_nettype wire

// ----- rtl/rbd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rbd_back import rbd_pkg::*; #(
  parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF,
  parameter int MAX_GROUP     = MAX_GROUP_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire dcfg_t dcfg,
  input  wire logic  q_valid,
  output logic       q_ready,
  input  wire op_t   q_op,
  output logic       init_busy,
  rbd_out_if.source  out_ch
);

  localparam int AW     = $clog2(MAX_OUT_WIDTH);
  localparam int WIN_IW = $clog2(MAX_GROUP);
  localparam int SUM_W  = $clog2(MAX_GROUP * 63 + 1);
  localparam int GRP_W  = $clog2(MAX_GROUP + 1);
  localparam int RCP_K  = SUM_W + 2 * GRP_W;
  localparam int PRD_W  = SUM_W + RCP_W;

  back_state_t       state_r, state_nxt;
  logic [AW-1:0]     init_addr_r;
  logic [PIX_W-1:0]  store_mem [MAX_OUT_WIDTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic [AW-1:0]     rd_addr;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [PIX_W-1:0]  wr_data;

  logic [PIX_W-1:0]  win_r [MAX_GROUP];
  op_t               cur_r;
  logic [SUM_W-1:0]  sr_r, sg_r, sb_r;
  logic [SUM_W-1:0]  sr, sg, sb;
  logic [PIX_W-1:0]  near, near_r;
  logic [5:0]        qr_r, qg_r, qb_r;
  logic [PRD_W-1:0]  pr, pg, pb;
  logic [PIX_W-1:0]  avg;
  logic [PIX_W-1:0]  val;
  logic [PIX_W-1:0]  keep;
  logic              wr_go;
  logic              take_col;

  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;
  logic [COL_W-1:0]  out_col_r;
  logic signed [TAG_W-1:0] out_line_r;
  logic              out_last_r;

  assign init_busy = (state_r == B_INIT);
  assign take_col  = (state_r == B_IDLE) && q_valid && (q_op.kind == OP_COL);
  assign wr_go     = !cur_r.emit || !out_valid_r || out_ch.ready;

  // Channel sums over the group; window slot j holds source pixel idx-j
  always_comb begin
    sr = '0;
    sg = '0;
    sb = '0;
    for (int j = 0; j < MAX_GROUP; j++) begin
      if (((DOFF_W+1)'(j) <= (DOFF_W+1)'(q_op.doff)) &&
          ((DOFF_W+1)'(j) + (DOFF_W+1)'(dcfg.c) > (DOFF_W+1)'(q_op.doff))) begin
        sr = sr + SUM_W'((win_r[j] & RED_MASK) >> RED_LSB);
        sg = sg + SUM_W'((win_r[j] & GRN_MASK) >> GRN_LSB);
        sb = sb + SUM_W'(win_r[j] & BLU_MASK);
      end
    end
    if (q_op.doff < DOFF_W'(MAX_GROUP)) begin
      near = win_r[q_op.doff[WIN_IW-1:0]];
    end else begin
      near = '0;
    end
  end

  // Divide by c*c through the reciprocal
  always_comb begin
    pr = PRD_W'(sr_r) * PRD_W'(dcfg.recip);
    pg = PRD_W'(sg_r) * PRD_W'(dcfg.recip);
    pb = PRD_W'(sb_r) * PRD_W'(dcfg.recip);
  end

  // Combine with the row store entry
  always_comb begin
    avg = ((PIX_W'(qr_r) << RED_LSB) & RED_MASK) |
          ((PIX_W'(qg_r) << GRN_LSB) & GRN_MASK) |
          (PIX_W'(qb_r) & BLU_MASK);
    if (dcfg.mode) begin
      val  = cur_r.first_row ? near_r : rd_data_r;
      keep = cur_r.emit ? '0 : val;
    end else if (cur_r.emit) begin
      val  = rd_data_r + avg;
      keep = dcfg.frac ? avg : '0;
    end else begin
      val  = rd_data_r + avg;
      keep = val;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_INIT: if (init_addr_r == AW'(MAX_OUT_WIDTH - 1)) state_nxt = B_IDLE;
      B_IDLE: if (take_col) state_nxt = B_MUL;
      B_MUL:  state_nxt = B_WR;
      B_WR:   if (wr_go) state_nxt = B_IDLE;
      default: state_nxt = B_IDLE;
    endcase
  end

  // Queue pop and memory port
  always_comb begin
    q_ready = 1'b0;
    wr_en   = 1'b0;
    wr_addr = cur_r.x[AW-1:0];
    wr_data = keep;
    rd_addr = cur_r.x[AW-1:0];
    unique case (state_r)
      B_INIT: begin
        wr_en   = 1'b1;
        wr_addr = init_addr_r;
        wr_data = '0;
      end
      B_IDLE: begin
        q_ready = 1'b1;
        rd_addr = q_op.x[AW-1:0];
        if (q_valid && (q_op.kind == OP_ZERO)) begin
          wr_en   = 1'b1;
          wr_addr = q_op.x[AW-1:0];
          wr_data = '0;
        end
      end
      B_MUL: begin
      end
      B_WR: wr_en = wr_go;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    rd_data_r <= store_mem[rd_addr];
  end

  // Shift the pixel window; a line's first pixel clears the rest
  always_ff @(posedge clk) begin
    if ((state_r == B_IDLE) && q_valid && (q_op.kind == OP_PIXEL)) begin
      win_r[0] <= q_op.pixel;
      for (int j = 1; j < MAX_GROUP; j++) begin
        win_r[j] <= q_op.first ? '0 : win_r[j-1];
      end
    end
  end

  // Column pipeline payload
  always_ff @(posedge clk) begin
    if (take_col) begin
      cur_r  <= q_op;
      sr_r   <= sr;
      sg_r   <= sg;
      sb_r   <= sb;
      near_r <= near;
    end
    if (state_r == B_MUL) begin
      qr_r <= 6'(pr >> RCP_K);
      qg_r <= 6'(pg >> RCP_K);
      qb_r <= 6'(pb >> RCP_K);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if ((state_r == B_WR) && wr_go && cur_r.emit) begin
      out_pix_r  <= val;
      out_col_r  <= cur_r.x[COL_W-1:0];
      out_line_r <= cur_r.tag;
      out_last_r <= cur_r.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_INIT;
      init_addr_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_INIT) init_addr_r <= init_addr_r + 1'b1;
      if ((state_r == B_WR) && wr_go && cur_r.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pixel_out   = out_pix_r;
  assign out_ch.column      = out_col_r;
  assign out_ch.out_line    = out_line_r;
  assign out_ch.last_of_row = out_last_r;

endmodule
`default_nettype wire

// ----- rtl/rgb565_box_downscaler_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// RGB565 box downscaler. Source pixels enter one word per accept on in_ch;
// downscaled pixels leave on out_ch with their column, line tag and an end
// of row mark. A front stage takes a pixel and then steps through every
// output column it completes, queueing one job for the pixel and one per
// column; a back stage runs a pixel job as a window shift and a column job
// as window sum, reciprocal multiply and row store read-modify-write, and
// takes no new job until the column job is written. At the end of an
// emitting row the unused row store entries are cleared, one per cycle
// while the queue has room. After reset the back stage clears the row
// store before the first pixel is taken, and input is held after every
// configuration write while the derived settings update.
module rgb565_box_downscaler_core import rbd_pkg::*; #(
  parameter int MAX_OUT_WIDTH = MAX_OUT_WIDTH_DEF,
  parameter int MAX_GROUP     = MAX_GROUP_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  rbd_in_if.sink                 in_ch,
  rbd_out_if.source              out_ch,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_idx,
  input  wire logic [CFG_W-1:0]  cfg_wdata
);

  localparam int SUM_W = $clog2(MAX_GROUP * 63 + 1);
  localparam int GRP_W = $clog2(MAX_GROUP + 1);
  localparam int RCP_K = SUM_W + 2 * GRP_W;
  localparam logic [F_W-1:0] F_MAX = F_W'(MAX_GROUP * FACTOR_SCALE);

  logic [CFG_W-1:0]     factor_r;
  logic [CFG_W-1:0]     width_r;
  logic                 mode_r;
  logic [1:0]           settle_r;
  logic [F_W-1:0]       feff_r;
  logic [XW-1:0]        weff_r;
  logic [F_W-1:0]       feff2_r;
  logic [FQ_W-1:0]      fq_r;
  logic [F_W+14:0]      fq_prod;
  logic [F_W-1:0]       frem;
  logic [CNT_W-1:0]     cgrp;
  dcfg_t                dcfg_r;
  logic [RCP_W-1:0]     rcp_tab [MAX_GROUP+1];
  hold_t                hold;
  logic                 push_valid;
  logic                 push_ready;
  op_t                  push_op;
  logic                 q_valid;
  logic                 q_ready;
  op_t                  q_op;
  logic                 init_busy;

  // Reciprocals of c*c, rounded up
  for (genvar gi = 0; gi <= MAX_GROUP; gi++) begin : g_rcp
    if (gi == 0) begin : g_zero
      assign rcp_tab[gi] = '0;
    end else begin : g_val
      localparam longint unsigned RV =
        ((64'd1 << RCP_K) + gi * gi - 1) / (gi * gi);
      assign rcp_tab[gi] = RCP_W'(RV);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      factor_r <= FACTOR_RST;
      width_r  <= WIDTH_RST;
      mode_r   <= 1'b0;
      settle_r <= 2'(SETTLE);
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_FACTOR: factor_r <= cfg_wdata;
          REG_WIDTH:  width_r  <= cfg_wdata;
          REG_MODE:   mode_r   <= cfg_wdata[0];
          default: begin
          end
        endcase
        settle_r <= 2'(SETTLE);
      end else if (settle_r != '0) begin
        settle_r <= settle_r - 1'b1;
      end
    end
  end

  // Derived settings: clamp, split factor into quotient and remainder
  always_comb begin
    fq_prod = (F_W+15)'(feff_r) * (F_W+15)'(QMUL);
    frem    = feff2_r - F_W'(fq_r) * F_W'(FACTOR_SCALE);
    cgrp    = CNT_W'(fq_r) + CNT_W'(frem != '0);
  end

  always_ff @(posedge clk) begin
    if (F_W'(factor_r) < F_W'(F_MIN)) begin
      feff_r <= F_W'(F_MIN);
    end else if (F_W'(factor_r) > F_MAX) begin
      feff_r <= F_MAX;
    end else begin
      feff_r <= F_W'(factor_r);
    end
    weff_r <= (XW'(width_r) > XW'(MAX_OUT_WIDTH)) ? XW'(MAX_OUT_WIDTH) : XW'(width_r);
    feff2_r      <= feff_r;
    fq_r         <= FQ_W'(fq_prod >> QSH);
    dcfg_r.fq    <= fq_r;
    dcfg_r.fr    <= FR_W'(frem);
    dcfg_r.c     <= cgrp;
    dcfg_r.frac  <= (frem != '0);
    dcfg_r.mode  <= mode_r;
    dcfg_r.w     <= weff_r;
    dcfg_r.recip <= rcp_tab[cgrp[GRP_W-1:0]];
  end

  assign hold.init_busy   = init_busy;
  assign hold.settle_busy = (settle_r != '0);

  rbd_front #(
    .MAX_GROUP (MAX_GROUP)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .dcfg       (dcfg_r),
    .hold       (hold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op)
  );

  rbd_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_op    (push_op),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_op     (q_op)
  );

  rbd_back #(
    .MAX_OUT_WIDTH (MAX_OUT_WIDTH),
    .MAX_GROUP     (MAX_GROUP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dcfg      (dcfg_r),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_op      (q_op),
    .init_busy (init_busy),
    .out_ch    (out_ch)
  );

  // No pixel may enter before the row store is cleared or settings settle
  `RBD_ASSERT(a_no_accept_when_held, clk, rst_n, (in_ch.valid && in_ch.ready) |-> (!init_busy && (settle_r == '0)), "pixel accepted while held")
  // The front only offers ready when its pixel job has room in the queue
  `RBD_ASSERT(a_ready_needs_room, clk, rst_n, in_ch.ready |-> push_ready, "ready without queue room")
  // Nothing leaves while the row store is being cleared
  `RBD_NEVER(a_no_out_in_init, clk, rst_n, init_busy && out_ch.valid, "result during clear pass")

endmodule
`default_nettype wire
